/* design/rqh_pkg.sv */
// shared types and codes for the ring queue with history stack
package rqh_pkg;

    localparam int TAG_FIELD_W = 32;
    localparam int POS_FIELD_W = 7;

    typedef enum logic [1:0] {
        MODE_ENQ    = 2'd0,
        MODE_CALL   = 2'd1,
        MODE_LIST_Q = 2'd2,
        MODE_LIST_H = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } t_state;

    typedef enum logic [1:0] {
        K_POP    = 2'd0,
        K_LIST_Q = 2'd1,
        K_LIST_H = 2'd2
    } t_kind;

    typedef struct packed {
        t_mode                  mode;
        logic [TAG_FIELD_W-1:0] entry_tag;
    } t_in_req;

    typedef struct packed {
        t_status                status;
        logic [TAG_FIELD_W-1:0] tag_out;
        logic [POS_FIELD_W-1:0] position;
        logic                   history_dropped;
        logic                   last;
    } t_out_res;

endpackage

/* design/rqh_ram.sv */
// generic single-clock ram, one write port, one registered read port
module rqh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/ring_queue_with_history_stack.sv */
// top level: ring queue of tags with a lifo history of called tags
//
// input channel (i_in_valid / o_in_ready / i_in_data) takes one request:
// enqueue a tag, call the oldest tag, list the queue or list the history.
// output channel (o_out_valid / i_out_ready / o_out_data) returns results;
// every request gives at least one result and the final one has last set.
// queue and history each live in a ram with a registered read.
// enqueue and every refused or empty request: the result register is loaded
// when the request is taken, and a new request may follow once it moves on.
// call next and listings: the ram read adds a register, so the first result
// passes the ram output and then the core result register; a listing then
// streams one entry per cycle while the result register has room, and the
// input is held until the walk ends. the ram read port paces the walk.
// results pass a core result register and then an output register, so one
// request can be taken while an earlier result waits at the output.
// when the receiver stalls, both registers fill and the walk pauses with
// its read data held in the ram output; nothing is lost or repeated.
// reset empties queue and history (counts and indexes go to zero); ram
// contents are not cleared and are never read before being written.
module ring_queue_with_history_stack #(
    parameter int DEPTH    = 64,
    parameter int TAG_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rqh_pkg::t_in_req i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output rqh_pkg::t_out_res o_out_data
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int EXT_W  = (TAG_BITS > rqh_pkg::TAG_FIELD_W) ? TAG_BITS
                                                               : rqh_pkg::TAG_FIELD_W;

    // ring index step with wrap at the configured depth
    function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] idx);
        logic [ADDR_W-1:0] nxt;
        nxt = (idx == ADDR_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
        return nxt;
    endfunction

    // control state
    rqh_pkg::t_state  r_state, n_state;
    rqh_pkg::t_kind   r_kind, n_kind;
    logic [ADDR_W-1:0] r_head, n_head;
    logic [ADDR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0]  r_q_count, n_q_count;
    logic [CNT_W-1:0]  r_h_count, n_h_count;
    logic [ADDR_W-1:0] r_idx, n_idx;      // next address the walk reads
    logic [CNT_W-1:0]  r_left, n_left;    // reads still to issue
    logic [CNT_W-1:0]  r_pos, n_pos;      // position of the pending entry
    logic              r_rd_pend, n_rd_pend;
    logic              r_res_valid, n_res_valid;
    logic              r_out_valid, n_out_valid;

    // result payload
    rqh_pkg::t_out_res r_res, n_res;
    rqh_pkg::t_out_res r_out;

    // ram ports
    logic                q_wr_en, q_rd_en, h_wr_en, h_rd_en;
    logic [ADDR_W-1:0]   q_wr_addr, q_rd_addr, h_wr_addr, h_rd_addr;
    logic [TAG_BITS-1:0] q_wr_data, q_rd_data, h_rd_data;

    logic                in_acc, move, res_free, consume, issue;
    logic                q_empty, q_full, h_empty, h_full, needs_walk;
    logic [TAG_BITS-1:0] in_tag, rd_sel;
    logic [EXT_W-1:0]    in_ext, rd_ext;

    // handshake glue: result register frees when it moves to the output
    assign move     = r_res_valid && (!r_out_valid || i_out_ready);
    assign res_free = !r_res_valid || move;
    assign o_in_ready = (r_state == rqh_pkg::S_IDLE) && res_free;
    assign in_acc   = i_in_valid && o_in_ready;

    assign q_empty = (r_q_count == '0);
    assign q_full  = (r_q_count == CNT_W'(DEPTH));
    assign h_empty = (r_h_count == '0);
    assign h_full  = (r_h_count == CNT_W'(DEPTH));

    // walk: take the held ram word when the result register has room,
    // and launch the next read only once the held word is gone
    assign consume = (r_state == rqh_pkg::S_WALK) && r_rd_pend && res_free;
    assign issue   = (r_state == rqh_pkg::S_WALK) && (r_left != '0)
                     && (!r_rd_pend || consume);

    assign needs_walk = ((i_in_data.mode == rqh_pkg::MODE_CALL)   && !q_empty)
                     || ((i_in_data.mode == rqh_pkg::MODE_LIST_Q) && !q_empty)
                     || ((i_in_data.mode == rqh_pkg::MODE_LIST_H) && !h_empty);

    // tag width conversions between the 32-bit field and the stored width
    assign in_ext = EXT_W'(i_in_data.entry_tag);
    assign in_tag = in_ext[TAG_BITS-1:0];
    assign rd_sel = (r_kind == rqh_pkg::K_LIST_H) ? h_rd_data : q_rd_data;
    assign rd_ext = EXT_W'(rd_sel);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rqh_pkg::S_IDLE: begin
                if (in_acc && needs_walk) begin
                    n_state = rqh_pkg::S_WALK;
                end
            end
            rqh_pkg::S_WALK: begin
                if (consume && (r_left == '0)) begin
                    n_state = rqh_pkg::S_IDLE;
                end
            end
            default: n_state = rqh_pkg::S_IDLE;
        endcase
    end

    // datapath, ram control and result generation
    always_comb begin
        n_kind      = r_kind;
        n_head      = r_head;
        n_tail      = r_tail;
        n_q_count   = r_q_count;
        n_h_count   = r_h_count;
        n_idx       = r_idx;
        n_left      = r_left;
        n_pos       = r_pos;
        n_rd_pend   = r_rd_pend;
        n_res       = r_res;
        n_res_valid = move ? 1'b0 : r_res_valid;
        q_wr_en     = 1'b0;
        q_wr_addr   = r_tail;
        q_wr_data   = in_tag;
        q_rd_en     = 1'b0;
        q_rd_addr   = r_idx;
        h_wr_en     = 1'b0;
        h_wr_addr   = r_h_count[ADDR_W-1:0];
        h_rd_en     = 1'b0;
        h_rd_addr   = r_idx;

        unique case (r_state)
            rqh_pkg::S_IDLE: begin
                if (in_acc) begin
                    // immediate result, overwritten below for a walk
                    n_res.status          = rqh_pkg::ST_OK;
                    n_res.tag_out         = '0;
                    n_res.position        = '0;
                    n_res.history_dropped = 1'b0;
                    n_res.last            = 1'b1;
                    n_res_valid           = 1'b1;
                    n_pos                 = CNT_W'(1);
                    n_rd_pend             = 1'b1;
                    unique case (i_in_data.mode)
                        rqh_pkg::MODE_ENQ: begin
                            if (q_full) begin
                                n_res.status = rqh_pkg::ST_FULL;
                            end else begin
                                q_wr_en   = 1'b1;
                                n_tail    = ring_next(r_tail);
                                n_q_count = r_q_count + 1'b1;
                            end
                            n_rd_pend = 1'b0;
                        end
                        rqh_pkg::MODE_CALL: begin
                            if (q_empty) begin
                                n_res.status = rqh_pkg::ST_EMPTY;
                                n_rd_pend    = 1'b0;
                            end else begin
                                q_rd_en     = 1'b1;
                                q_rd_addr   = r_head;
                                n_head      = ring_next(r_head);
                                n_q_count   = r_q_count - 1'b1;
                                n_kind      = rqh_pkg::K_POP;
                                n_left      = '0;
                                n_res_valid = 1'b0;
                            end
                        end
                        rqh_pkg::MODE_LIST_Q: begin
                            if (q_empty) begin
                                n_res.status = rqh_pkg::ST_EMPTY;
                                n_rd_pend    = 1'b0;
                            end else begin
                                q_rd_en     = 1'b1;
                                q_rd_addr   = r_head;
                                n_idx       = ring_next(r_head);
                                n_left      = r_q_count - 1'b1;
                                n_kind      = rqh_pkg::K_LIST_Q;
                                n_res_valid = 1'b0;
                            end
                        end
                        rqh_pkg::MODE_LIST_H: begin
                            if (h_empty) begin
                                n_res.status = rqh_pkg::ST_EMPTY;
                                n_rd_pend    = 1'b0;
                            end else begin
                                // newest entry first, walking down
                                h_rd_en     = 1'b1;
                                h_rd_addr   = ADDR_W'(r_h_count - 1'b1);
                                n_idx       = ADDR_W'(r_h_count - 2'd2);
                                n_left      = r_h_count - 1'b1;
                                n_kind      = rqh_pkg::K_LIST_H;
                                n_res_valid = 1'b0;
                            end
                        end
                        default: n_rd_pend = 1'b0;
                    endcase
                end
            end
            rqh_pkg::S_WALK: begin
                if (consume) begin
                    n_res.status          = rqh_pkg::ST_OK;
                    n_res.tag_out         = rd_ext[rqh_pkg::TAG_FIELD_W-1:0];
                    n_res.position        = (r_kind == rqh_pkg::K_POP) ? '0
                                          : rqh_pkg::POS_FIELD_W'(r_pos);
                    n_res.history_dropped = (r_kind == rqh_pkg::K_POP) && h_full;
                    n_res.last            = (r_left == '0);
                    n_res_valid           = 1'b1;
                    n_pos                 = r_pos + 1'b1;
                    n_rd_pend             = 1'b0;
                    // popped tag goes on the history stack unless it is full
                    if ((r_kind == rqh_pkg::K_POP) && !h_full) begin
                        h_wr_en   = 1'b1;
                        n_h_count = r_h_count + 1'b1;
                    end
                end
                if (issue) begin
                    n_rd_pend = 1'b1;
                    n_left    = r_left - 1'b1;
                    if (r_kind == rqh_pkg::K_LIST_H) begin
                        h_rd_en = 1'b1;
                        n_idx   = r_idx - 1'b1;
                    end else begin
                        q_rd_en = 1'b1;
                        n_idx   = ring_next(r_idx);
                    end
                end
            end
            default: begin
                n_rd_pend = 1'b0;
            end
        endcase
    end

    // output register valid: load on move, clear when taken
    always_comb begin
        priority if (move) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rqh_pkg::S_IDLE;
            r_kind      <= rqh_pkg::K_POP;
            r_head      <= '0;
            r_tail      <= '0;
            r_q_count   <= '0;
            r_h_count   <= '0;
            r_idx       <= '0;
            r_left      <= '0;
            r_pos       <= '0;
            r_rd_pend   <= 1'b0;
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_q_count   <= n_q_count;
            r_h_count   <= n_h_count;
            r_idx       <= n_idx;
            r_left      <= n_left;
            r_pos       <= n_pos;
            r_rd_pend   <= n_rd_pend;
            r_res_valid <= n_res_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (move) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // queue ring storage
    rqh_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (DEPTH)
    ) u_queue_ram (
        .i_clk     (i_clk),
        .i_wr_en   (q_wr_en),
        .i_wr_addr (q_wr_addr),
        .i_wr_data (q_wr_data),
        .i_rd_en   (q_rd_en),
        .i_rd_addr (q_rd_addr),
        .o_rd_data (q_rd_data)
    );

    // history stack storage, written with the word read from the queue
    rqh_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (DEPTH)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (h_wr_en),
        .i_wr_addr (h_wr_addr),
        .i_wr_data (q_rd_data),
        .i_rd_en   (h_rd_en),
        .i_rd_addr (h_rd_addr),
        .o_rd_data (h_rd_data)
    );

    // counts stay within the store depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q_count <= CNT_W'(DEPTH)) && (r_h_count <= CNT_W'(DEPTH)))
        else $error("queue or history count beyond depth");

    // a walk always has a read in flight or one still to issue
    a_walk_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rqh_pkg::S_WALK) |-> (r_rd_pend || (r_left != '0)))
        else $error("walk state with nothing left to deliver");

    // both result registers full and stalled: no new request taken
    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && r_res_valid) |-> !o_in_ready)
        else $error("request taken with no room for its result");

    // a call on a non-empty queue decrements the queue count
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.mode == rqh_pkg::MODE_CALL) && !q_empty)
        |=> (r_q_count == $past(r_q_count) - 1'b1))
        else $error("queue count not decremented on call");

endmodule
